/* sv/resp_array_to_command_line_top_assert.svh */
`ifndef RESP_ARRAY_TO_COMMAND_LINE_TOP_ASSERT_SVH
`define RESP_ARRAY_TO_COMMAND_LINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RA2CL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define RA2CL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ra2cl_pkg.sv */
package ra2cl_pkg;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // results per item at most, and output queue depth
  localparam int MAX_RES   = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  typedef enum logic [3:0] {
    PH_START,
    PH_PLAIN,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_PAYLOAD,
    PH_TRAIL1,
    PH_TRAIL2,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       err;
  } result_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]      cnt;
    result_t [MAX_RES-1:0]     res;
  } push_t;

endpackage

/* sv/ra2cl_outq.sv */
module ra2cl_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ra2cl_pkg::push_t  push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ra2cl_pkg::result_t out_res_o
);

  ra2cl_pkg::result_t mem_q [ra2cl_pkg::Q_DEPTH];

  logic [ra2cl_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ra2cl_pkg::Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ra2cl_pkg::Q_CNT_W-1:0] count_q, count_d;
  logic                          pop;

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = count_q <= ra2cl_pkg::Q_CNT_W'(ra2cl_pkg::Q_DEPTH - ra2cl_pkg::MAX_RES);

  always_comb begin
    wr_ptr_d = wr_ptr_q + ra2cl_pkg::Q_PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + ra2cl_pkg::Q_PTR_W'(pop);
    count_d  = count_q + ra2cl_pkg::Q_CNT_W'(push_i.cnt) - ra2cl_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ra2cl_pkg::MAX_RES; k++) begin
      if (ra2cl_pkg::RES_CNT_W'(k) < push_i.cnt) begin
        mem_q[wr_ptr_q + ra2cl_pkg::Q_PTR_W'(k)] <= push_i.res[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* sv/resp_array_to_command_line_top.sv */
// an item is registered at the input, then pushed to the output queue
// throughput: one item per cycle while the output side keeps up
// an item giving two or three results holds input until the 4-entry queue has room
// reset: asynchronous, active low; parser returns to start of message, queue empties
module resp_array_to_command_line_top #(
  parameter int COUNT_BITS  = 16,
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_byte_o,
  output logic       out_has_byte_o,
  output logic       out_last_o,
  output logic       out_error_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  `include "resp_array_to_command_line_top_assert.svh"

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_acc;
  logic       proc;
  logic       room;

  ra2cl_pkg::phase_e        phase_q, phase_d;
  logic [COUNT_BITS-1:0]    elem_q, elem_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic                     digit_q, digit_d;
  logic                     first_q, first_d;
  logic [1:0][7:0]          held_q, held_d;
  logic [1:0]               held_cnt_q, held_cnt_d;
  logic                     err_q, err_d;

  logic [COUNT_BITS+3:0]    cnt_acc;
  logic [LENGTH_BITS+3:0]   len_acc;
  logic                     is_digit;
  logic [3:0]               dig;

  logic [2:0][7:0]          ebyte;
  logic [1:0]               ne;
  logic [1:0]               nplain;
  logic                     marker;
  logic                     fin_err;
  logic                     complete;

  ra2cl_pkg::push_t         push;
  ra2cl_pkg::result_t       out_res;

  assign in_acc     = in_valid_i && in_ready_o;
  assign proc       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  assign is_digit = (in_byte_q >= ra2cl_pkg::CH_ZERO) && (in_byte_q <= ra2cl_pkg::CH_NINE);
  assign dig      = 4'(in_byte_q - ra2cl_pkg::CH_ZERO);
  assign cnt_acc  = ({4'b0, elem_q} << 3) + ({4'b0, elem_q} << 1) + (COUNT_BITS + 4)'(dig);
  assign len_acc  = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1) + (LENGTH_BITS + 4)'(dig);

  always_comb begin
    phase_d    = phase_q;
    elem_d     = elem_q;
    len_d      = len_q;
    digit_d    = digit_q;
    first_d    = first_q;
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    err_d      = err_q;
    ebyte      = '0;
    ne         = 2'd0;
    nplain     = 2'd0;
    marker     = 1'b0;
    fin_err    = 1'b0;
    complete   = 1'b0;

    if (proc) begin
      if (phase_q == ra2cl_pkg::PH_START) begin
        if (in_byte_q == ra2cl_pkg::CH_STAR) begin
          phase_d = ra2cl_pkg::PH_COUNT;
          elem_d  = '0;
          digit_d = 1'b0;
        end else begin
          phase_d = ra2cl_pkg::PH_PLAIN;
        end
      end else if (phase_q != ra2cl_pkg::PH_PLAIN && !err_q) begin
        case (phase_q)
          ra2cl_pkg::PH_COUNT, ra2cl_pkg::PH_LEN: begin
            if (is_digit) begin
              if (phase_q == ra2cl_pkg::PH_COUNT) begin
                if (|cnt_acc[COUNT_BITS+3:COUNT_BITS]) begin
                  err_d = 1'b1;
                end else begin
                  elem_d = cnt_acc[COUNT_BITS-1:0];
                end
              end else begin
                if (|len_acc[LENGTH_BITS+3:LENGTH_BITS]) begin
                  err_d = 1'b1;
                end else begin
                  len_d = len_acc[LENGTH_BITS-1:0];
                end
              end
              digit_d = 1'b1;
            end else if (in_byte_q == ra2cl_pkg::CH_CR && digit_q) begin
              phase_d = (phase_q == ra2cl_pkg::PH_COUNT) ? ra2cl_pkg::PH_COUNT_LF
                                                         : ra2cl_pkg::PH_LEN_LF;
            end else begin
              err_d = 1'b1;
            end
          end
          ra2cl_pkg::PH_COUNT_LF: begin
            if (in_byte_q != ra2cl_pkg::CH_LF) begin
              err_d = 1'b1;
            end else begin
              phase_d = (elem_q == '0) ? ra2cl_pkg::PH_DONE : ra2cl_pkg::PH_DOLLAR;
            end
          end
          ra2cl_pkg::PH_DOLLAR: begin
            if (in_byte_q != ra2cl_pkg::CH_DOLLAR) begin
              err_d = 1'b1;
            end else begin
              phase_d = ra2cl_pkg::PH_LEN;
              len_d   = '0;
              digit_d = 1'b0;
            end
          end
          ra2cl_pkg::PH_LEN_LF: begin
            if (in_byte_q != ra2cl_pkg::CH_LF) begin
              err_d = 1'b1;
            end else begin
              if (!first_q) begin
                ebyte[0] = ra2cl_pkg::CH_SPACE;
                ne       = 2'd1;
              end
              first_d = 1'b0;
              phase_d = (len_q == '0) ? ra2cl_pkg::PH_TRAIL1 : ra2cl_pkg::PH_PAYLOAD;
            end
          end
          ra2cl_pkg::PH_PAYLOAD: begin
            ebyte[0] = in_byte_q;
            ne       = 2'd1;
            len_d    = len_q - LENGTH_BITS'(1);
            if (len_q == LENGTH_BITS'(1)) begin
              phase_d = ra2cl_pkg::PH_TRAIL1;
            end
          end
          ra2cl_pkg::PH_TRAIL1: begin
            phase_d = ra2cl_pkg::PH_TRAIL2;
          end
          ra2cl_pkg::PH_TRAIL2: begin
            elem_d  = elem_q - COUNT_BITS'(1);
            phase_d = (elem_q == COUNT_BITS'(1)) ? ra2cl_pkg::PH_DONE : ra2cl_pkg::PH_DOLLAR;
          end
          default: begin
          end
        endcase
      end

      // plain text with a two-byte holdback; a trailing cr, lf or cr-lf is dropped
      if (phase_d == ra2cl_pkg::PH_PLAIN) begin
        if (!in_last_q) begin
          if (held_cnt_q == 2'd2) begin
            ebyte[0]  = held_q[0];
            ne        = 2'd1;
            held_d[0] = held_q[1];
            held_d[1] = in_byte_q;
          end else begin
            held_d[held_cnt_q[0]] = in_byte_q;
            held_cnt_d            = held_cnt_q + 2'd1;
          end
        end else begin
          ebyte[0] = (held_cnt_q != 2'd0) ? held_q[0] : in_byte_q;
          ebyte[1] = (held_cnt_q == 2'd2) ? held_q[1] : in_byte_q;
          ebyte[2] = in_byte_q;
          nplain   = held_cnt_q + 2'd1;
          if (in_byte_q == ra2cl_pkg::CH_LF) begin
            nplain = held_cnt_q;
            if (held_cnt_q != 2'd0 &&
                held_q[1'(held_cnt_q - 2'd1)] == ra2cl_pkg::CH_CR) begin
              nplain = held_cnt_q - 2'd1;
            end
          end else if (in_byte_q == ra2cl_pkg::CH_CR) begin
            nplain = held_cnt_q;
          end
          ne = nplain;
        end
      end

      if (in_last_q) begin
        if (phase_d != ra2cl_pkg::PH_PLAIN) begin
          complete = (phase_d == ra2cl_pkg::PH_DONE) ||
                     ((phase_d == ra2cl_pkg::PH_TRAIL1 || phase_d == ra2cl_pkg::PH_TRAIL2) &&
                      elem_d == COUNT_BITS'(1));
          fin_err  = err_d || !complete;
        end
        if (ne == 2'd0) begin
          ne       = 2'd1;
          marker   = 1'b1;
          ebyte[0] = 8'h00;
        end
        phase_d    = ra2cl_pkg::PH_START;
        elem_d     = '0;
        len_d      = '0;
        digit_d    = 1'b0;
        first_d    = 1'b1;
        held_cnt_d = 2'd0;
        err_d      = 1'b0;
      end
    end
  end

  always_comb begin
    push.cnt = proc ? ra2cl_pkg::RES_CNT_W'(ne) : '0;
    for (int k = 0; k < ra2cl_pkg::MAX_RES; k++) begin
      push.res[k].data     = ebyte[k];
      push.res[k].has_byte = !marker;
      push.res[k].last     = in_last_q && (2'(k) == ne - 2'd1);
      push.res[k].err      = fin_err && (2'(k) == ne - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ra2cl_pkg::PH_START;
      elem_q     <= '0;
      len_q      <= '0;
      digit_q    <= 1'b0;
      first_q    <= 1'b1;
      held_cnt_q <= 2'd0;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      elem_q     <= elem_d;
      len_q      <= len_d;
      digit_q    <= digit_d;
      first_q    <= first_d;
      held_cnt_q <= held_cnt_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  ra2cl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign out_byte_o     = out_res.data;
  assign out_has_byte_o = out_res.has_byte;
  assign out_last_o     = out_res.last;
  assign out_error_o    = out_res.err;

  `RA2CL_ASSERT_IMP(a_held_only_plain, held_cnt_q != 2'd0, phase_q == ra2cl_pkg::PH_PLAIN, "held bytes outside plain text")
  `RA2CL_ASSERT_IMP(a_plain_no_err, phase_q == ra2cl_pkg::PH_PLAIN, !err_q, "error flag in plain text")
  `RA2CL_ASSERT_IMP(a_payload_len, phase_q == ra2cl_pkg::PH_PAYLOAD, len_q != '0, "payload phase with zero length")
  `RA2CL_ASSERT_NXT(a_last_clears, proc && in_last_q, phase_q == ra2cl_pkg::PH_START && held_cnt_q == 2'd0 && !err_q, "state not cleared after last item")

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_BITS  = 16;
  localparam int LENGTH_BITS = 32;
  localparam longint unsigned COUNT_MAX  = (64'd1 << COUNT_BITS) - 1;
  localparam longint unsigned LENGTH_MAX = (64'd1 << LENGTH_BITS) - 1;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } req_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] out_byte_o;
  logic       out_has_byte_o;
  logic       out_last_o;
  logic       out_error_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  req_t                request_bytes[$];
  ra2cl_pkg::result_t  cmd_bytes_due[$];
  req_t                next_req;
  ra2cl_pkg::result_t  want;
  int                  errors        = 0;
  int                  n_queued      = 0;
  int                  send_idle_pct = 13;
  int                  recv_idle_pct = 80;
  int                  hold_cycles   = 0;
  int                  cyc_cnt       = 0;

  // parser state of the predictor
  ra2cl_pkg::phase_e msg_phase    = ra2cl_pkg::PH_START;
  longint unsigned   elems_todo   = 0;
  longint unsigned   payload_todo = 0;
  logic              digits_seen  = 1'b0;
  logic              first_elem   = 1'b1;
  logic [7:0]        hold_buf[2];
  int                hold_n       = 0;
  logic              broken       = 1'b0;

  resp_array_to_command_line_top #(
    .COUNT_BITS (COUNT_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_byte_o    (out_byte_o),
    .out_has_byte_o(out_has_byte_o),
    .out_last_o    (out_last_o),
    .out_error_o   (out_error_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  function automatic void clear_msg();
    msg_phase    = ra2cl_pkg::PH_START;
    elems_todo   = 0;
    payload_todo = 0;
    digits_seen  = 1'b0;
    first_elem   = 1'b1;
    hold_n       = 0;
    broken       = 1'b0;
  endfunction

  function automatic ra2cl_pkg::result_t cmd_byte(logic [7:0] b);
    return ra2cl_pkg::result_t'{data: b, has_byte: 1'b1, last: 1'b0, err: 1'b0};
  endfunction

  // expected command-line results of one accepted item
  function automatic void parse_byte(logic [7:0] b, logic is_last);
    ra2cl_pkg::result_t res[$];
    ra2cl_pkg::result_t r;
    logic [7:0]         tail[$];
    longint unsigned    v;
    logic               complete;
    logic               err;
    err = 1'b0;
    if (msg_phase == ra2cl_pkg::PH_START) begin
      if (b == ra2cl_pkg::CH_STAR) begin
        msg_phase   = ra2cl_pkg::PH_COUNT;
        elems_todo  = 0;
        digits_seen = 1'b0;
      end else begin
        msg_phase = ra2cl_pkg::PH_PLAIN;
      end
    end else if (msg_phase != ra2cl_pkg::PH_PLAIN && !broken) begin
      case (msg_phase)
        ra2cl_pkg::PH_COUNT, ra2cl_pkg::PH_LEN: begin
          if (b >= ra2cl_pkg::CH_ZERO && b <= ra2cl_pkg::CH_NINE) begin
            v = (msg_phase == ra2cl_pkg::PH_COUNT) ? elems_todo : payload_todo;
            v = v * 10 + longint'(b - ra2cl_pkg::CH_ZERO);
            if (v > ((msg_phase == ra2cl_pkg::PH_COUNT) ? COUNT_MAX : LENGTH_MAX)) broken = 1'b1;
            else if (msg_phase == ra2cl_pkg::PH_COUNT) elems_todo = v;
            else payload_todo = v;
            digits_seen = 1'b1;
          end else if (b == ra2cl_pkg::CH_CR && digits_seen) begin
            if (msg_phase == ra2cl_pkg::PH_COUNT) msg_phase = ra2cl_pkg::PH_COUNT_LF;
            else msg_phase = ra2cl_pkg::PH_LEN_LF;
          end else begin
            broken = 1'b1;
          end
        end
        ra2cl_pkg::PH_COUNT_LF: begin
          if (b != ra2cl_pkg::CH_LF) broken = 1'b1;
          else if (elems_todo == 0) msg_phase = ra2cl_pkg::PH_DONE;
          else msg_phase = ra2cl_pkg::PH_DOLLAR;
        end
        ra2cl_pkg::PH_DOLLAR: begin
          if (b != ra2cl_pkg::CH_DOLLAR) begin
            broken = 1'b1;
          end else begin
            msg_phase    = ra2cl_pkg::PH_LEN;
            payload_todo = 0;
            digits_seen  = 1'b0;
          end
        end
        ra2cl_pkg::PH_LEN_LF: begin
          if (b != ra2cl_pkg::CH_LF) begin
            broken = 1'b1;
          end else begin
            if (!first_elem) res.push_back(cmd_byte(ra2cl_pkg::CH_SPACE));
            first_elem = 1'b0;
            msg_phase  = (payload_todo == 0) ? ra2cl_pkg::PH_TRAIL1 : ra2cl_pkg::PH_PAYLOAD;
          end
        end
        ra2cl_pkg::PH_PAYLOAD: begin
          res.push_back(cmd_byte(b));
          payload_todo--;
          if (payload_todo == 0) msg_phase = ra2cl_pkg::PH_TRAIL1;
        end
        ra2cl_pkg::PH_TRAIL1: msg_phase = ra2cl_pkg::PH_TRAIL2;
        ra2cl_pkg::PH_TRAIL2: begin
          elems_todo--;
          msg_phase = (elems_todo == 0) ? ra2cl_pkg::PH_DONE : ra2cl_pkg::PH_DOLLAR;
        end
        default: ;
      endcase
    end

    // plain text: two-byte holdback, trailing lf then cr dropped
    if (msg_phase == ra2cl_pkg::PH_PLAIN) begin
      if (!is_last) begin
        if (hold_n == 2) begin
          res.push_back(cmd_byte(hold_buf[0]));
          hold_buf[0] = hold_buf[1];
          hold_buf[1] = b;
        end else begin
          hold_buf[hold_n] = b;
          hold_n++;
        end
      end else begin
        for (int i = 0; i < hold_n; i++) tail.push_back(hold_buf[i]);
        tail.push_back(b);
        if (tail[tail.size() - 1] == ra2cl_pkg::CH_LF) tail.delete(tail.size() - 1);
        if (tail.size() > 0 && tail[tail.size() - 1] == ra2cl_pkg::CH_CR)
          tail.delete(tail.size() - 1);
        foreach (tail[i]) res.push_back(cmd_byte(tail[i]));
      end
    end

    if (is_last) begin
      if (msg_phase != ra2cl_pkg::PH_PLAIN) begin
        complete = (msg_phase == ra2cl_pkg::PH_DONE) ||
                   ((msg_phase == ra2cl_pkg::PH_TRAIL1 || msg_phase == ra2cl_pkg::PH_TRAIL2) &&
                    elems_todo == 1);
        err = broken || !complete;
      end
      if (res.size() == 0) res.push_back(ra2cl_pkg::result_t'{data: 8'h00, has_byte: 1'b0,
                                                               last: 1'b0, err: 1'b0});
      r = res[res.size() - 1];
      r.last = 1'b1;
      r.err  = err;
      res[res.size() - 1] = r;
      clear_msg();
    end
    foreach (res[i]) cmd_bytes_due.push_back(res[i]);
  endfunction

  function automatic void send_msg(logic [7:0] m[$]);
    foreach (m[i]) begin
      request_bytes.push_back(req_t'{data: m[i], fin: (i == m.size() - 1)});
      n_queued++;
    end
  endfunction

  function automatic void send_text(string s);
    logic [7:0] m[$];
    for (int i = 0; i < s.len(); i++) m.push_back(s[i]);
    send_msg(m);
  endfunction

  function automatic void push_num(ref logic [7:0] m[$], input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) m.push_back(s[i]);
  endfunction

  // mostly well-formed arrays, some of them truncated or with one byte corrupted
  function automatic void gen_array();
    logic [7:0]  m[$];
    int unsigned n_el;
    int unsigned len;
    int unsigned n_trail;
    int unsigned pos;
    int          pick;
    m.push_back(ra2cl_pkg::CH_STAR);
    pick = $urandom_range(19);
    n_el = (pick == 0) ? 65535 : (pick == 1) ? 65536 : $urandom_range(3);
    if ($urandom_range(9) == 0) m.push_back(ra2cl_pkg::CH_ZERO);
    push_num(m, n_el);
    m.push_back(ra2cl_pkg::CH_CR);
    m.push_back(ra2cl_pkg::CH_LF);
    for (int k = 0; k < ((n_el > 4) ? 2 : n_el); k++) begin
      m.push_back(ra2cl_pkg::CH_DOLLAR);
      pick = $urandom_range(29);
      len  = (pick == 0) ? 12 : $urandom_range(4);
      if (pick == 1) push_num(m, 64'd4294967296);
      else if (pick == 2) push_num(m, 64'd4294967295);
      else push_num(m, len);
      m.push_back(ra2cl_pkg::CH_CR);
      m.push_back(ra2cl_pkg::CH_LF);
      repeat (len) m.push_back(8'($urandom_range(255)));
      n_trail = (k + 1 == n_el && $urandom_range(3) == 0) ? $urandom_range(2) : 2;
      repeat (n_trail) m.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                            : ra2cl_pkg::CH_CR);
    end
    if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) m.push_back(8'($urandom_range(255)));
    pick = $urandom_range(9);
    if (pick == 0) begin
      pos = $urandom_range(1, m.size() - 1);
      m = m[0:pos - 1];
    end else if (pick == 1) begin
      pos = $urandom_range(1, m.size() - 1);
      m[pos] = 8'($urandom_range(255));
    end
    send_msg(m);
  endfunction

  function automatic void gen_plain();
    logic [7:0] m[$];
    repeat ($urandom_range(0, 8)) m.push_back(8'($urandom_range(255)));
    case ($urandom_range(5))
      0: begin
        m.push_back(ra2cl_pkg::CH_CR);
        m.push_back(ra2cl_pkg::CH_LF);
      end
      1: m.push_back(ra2cl_pkg::CH_LF);
      2: m.push_back(ra2cl_pkg::CH_CR);
      3: begin
        m.push_back(ra2cl_pkg::CH_LF);
        m.push_back(ra2cl_pkg::CH_LF);
      end
      default: ;
    endcase
    if (m.size() == 0) m.push_back(8'($urandom_range(255)));
    send_msg(m);
  endfunction

  function automatic void gen_noise();
    logic [7:0] m[$];
    m.push_back(ra2cl_pkg::CH_STAR);
    repeat ($urandom_range(0, 5)) m.push_back(8'($urandom_range(255)));
    send_msg(m);
  endfunction

  function automatic void gen_random(int n_bytes);
    int stop_at;
    int pick;
    stop_at = n_queued + n_bytes;
    while (n_queued < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 6) gen_array();
      else if (pick < 9) gen_plain();
      else gen_noise();
    end
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic drain();
    while (request_bytes.size() != 0 || in_valid_i || cmd_bytes_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
      in_last_i  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) parse_byte(in_byte_i, in_last_i);
      if (!in_valid_i || in_ready_o) begin
        if (request_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = request_bytes.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i  <= next_req.data;
          in_last_i  <= next_req.fin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_cnt     <= 0;
      hold_cycles <= 0;
    end else begin
      cyc_cnt <= cyc_cnt + 1;
      if (cyc_cnt == 150) begin
        hold_cycles <= 200;
      end else if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (cmd_bytes_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual byte %0h has %0b last %0b err %0b",
                   $time, out_byte_o, out_has_byte_o, out_last_o, out_error_o);
          errors++;
        end else begin
          want = cmd_bytes_due.pop_front();
          check_field("out_byte", want.data, out_byte_o);
          check_field("out_has_byte", want.has_byte, out_has_byte_o);
          check_field("out_last", want.last, out_last_o);
          check_field("out_error", want.err, out_error_o);
        end
      end
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty element with separator, unchecked trailing, end before last trailing
    send_text("*2\015\012$0\015\012--$1\015\012a");
    send_text("*0\015\012");
    send_text("\012");
    send_text("*-");
    send_text("*1\015\012!");
    send_msg({8'hFF, 8'h00});
    gen_random(110);
    drain();

    send_idle_pct = 80;
    recv_idle_pct = 13;
    gen_random(110);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(110);
    drain();

    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* resp_array_to_command_line_top.f */
+incdir+sv
sv/ra2cl_pkg.sv
sv/ra2cl_outq.sv
sv/resp_array_to_command_line_top.sv
dv/tb_top.sv
